### rtl/assert_macros.svh
// Assertion helpers shared by the RTL.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Implication checked on every clock edge outside reset.
`define ASSERT_IMPL(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Implication whose consequent is checked in the cycle after the antecedent.
`define ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

### rtl/netx_pkg.sv
package netx_pkg;

    localparam int TableEntries = 16;
    localparam int IdxW = $clog2(TableEntries);
    localparam int IdxCntW = $clog2(TableEntries + 1);

    localparam logic [2:0]  MaxTriesRst = 3'd3;
    localparam logic [3:0]  RecalcCountRst = 4'd4;
    localparam logic [15:0] RecalcIntervalRst = 16'd60;
    localparam logic [15:0] RatioNoAcks = 16'd511;

    localparam logic [1:0] CfgMaxTries = 2'd0;
    localparam logic [1:0] CfgRecalcCount = 2'd1;
    localparam logic [1:0] CfgRecalcInterval = 2'd2;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_SCAN,
        ST_READ,
        ST_DIV,
        ST_WRITE,
        ST_OUT
    } t_state;

    // Controller to datapath.
    typedef struct packed {
        logic load;       // capture input item, clear scan
        logic scan;       // compare one entry, advance scan index
        logic read;       // read selected entry, count attempts
        logic div_start;  // start the ratio division
        logic div_step;   // one restoring division step
        logic write;      // write back entry, build result
    } t_cmd;

    // Datapath to controller.
    typedef struct packed {
        logic scan_done;
        logic full;
        logic need_div;
        logic div_done;
    } t_stat;

endpackage

### rtl/neighbor_etx_estimator_unit.sv
// Neighbor ETX estimator. Each input transfer carries one transmitted
// frame's outcome; one result transfer comes back per frame with the table
// entry used, its ETX after the frame, and flags for a newly claimed entry,
// a full table, and an ETX recomputation. A frame goes through these steps
// in order: take the frame, scan the addresses (a match ends the scan
// early), read the entry and count attempts (skipped for a full table),
// recompute ETX with the bit-serial attempts/acks divider when needed,
// write back, and offer the result. One frame is in flight at a time; the
// result register holds until taken, and no new frame is taken before
// then. Configuration writes are accepted in any cycle and should only be
// issued while no frame is pending.
module neighbor_etx_estimator_unit (
    input  logic         i_clk,
    input  logic         i_rst_n,
    input  logic         s_axis_tvalid,
    output logic         s_axis_tready,
    // [63:0] dest_addr, [64] frame_is_ack, [65] ack_requested,
    // [68:66] acked_on_attempt, [100:69] now_seconds, [103:101] zero
    input  logic [103:0] s_axis_tdata,
    output logic         m_axis_tvalid,
    input  logic         m_axis_tready,
    // [3:0] entry_index, [19:4] link_etx, [20] new_entry, [21] table_full,
    // [22] etx_updated, [23] zero
    output logic [23:0]  m_axis_tdata,
    input  logic         i_cfg_valid,
    output logic         o_cfg_ready,
    input  logic [1:0]   i_cfg_index,
    input  logic [15:0]  i_cfg_data
);

    netx_pkg::t_cmd  cmd;
    netx_pkg::t_stat stat;

    logic [2:0]  r_max_tries;
    logic [3:0]  r_recalc_count;
    logic [15:0] r_recalc_interval;

    logic [3:0]  entry_index;
    logic [15:0] link_etx;
    logic        new_entry, table_full, etx_updated;

    // Always take configuration writes; unknown indexes are dropped.
    assign o_cfg_ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_max_tries <= netx_pkg::MaxTriesRst;
            r_recalc_count <= netx_pkg::RecalcCountRst;
            r_recalc_interval <= netx_pkg::RecalcIntervalRst;
        end else if (i_cfg_valid) begin
            unique case (i_cfg_index)
                netx_pkg::CfgMaxTries:       r_max_tries <= i_cfg_data[2:0];
                netx_pkg::CfgRecalcCount:    r_recalc_count <= i_cfg_data[3:0];
                netx_pkg::CfgRecalcInterval: r_recalc_interval <= i_cfg_data;
                default: ;
            endcase
        end
    end

    netx_ctrl u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (s_axis_tvalid),
        .o_in_ready  (s_axis_tready),
        .o_out_valid (m_axis_tvalid),
        .i_out_ready (m_axis_tready),
        .i_stat      (stat),
        .o_cmd       (cmd)
    );

    netx_dpath u_dpath (
        .i_clk              (i_clk),
        .i_rst_n            (i_rst_n),
        .i_cmd              (cmd),
        .o_stat             (stat),
        .i_dest_addr        (s_axis_tdata[63:0]),
        .i_frame_is_ack     (s_axis_tdata[64]),
        .i_ack_requested    (s_axis_tdata[65]),
        .i_acked_on_attempt (s_axis_tdata[68:66]),
        .i_now_seconds      (s_axis_tdata[100:69]),
        .i_max_tries        (r_max_tries),
        .i_recalc_count     (r_recalc_count),
        .i_recalc_interval  (r_recalc_interval),
        .o_entry_index      (entry_index),
        .o_link_etx         (link_etx),
        .o_new_entry        (new_entry),
        .o_table_full       (table_full),
        .o_etx_updated      (etx_updated)
    );

    assign m_axis_tdata = {1'b0, etx_updated, table_full, new_entry, link_etx, entry_index};

endmodule

### rtl/netx_ctrl.sv
`include "assert_macros.svh"

module netx_ctrl (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  logic            i_in_valid,
    output logic            o_in_ready,
    output logic            o_out_valid,
    input  logic            i_out_ready,
    input  netx_pkg::t_stat i_stat,
    output netx_pkg::t_cmd  o_cmd
);

    netx_pkg::t_state r_state, n_state;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= netx_pkg::ST_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    always_comb begin
        n_state = r_state;
        unique case (r_state)
            netx_pkg::ST_IDLE:  if (i_in_valid) n_state = netx_pkg::ST_SCAN;
            netx_pkg::ST_SCAN: begin
                if (i_stat.scan_done) begin
                    n_state = i_stat.full ? netx_pkg::ST_WRITE : netx_pkg::ST_READ;
                end
            end
            netx_pkg::ST_READ: begin
                n_state = i_stat.need_div ? netx_pkg::ST_DIV : netx_pkg::ST_WRITE;
            end
            netx_pkg::ST_DIV:   if (i_stat.div_done) n_state = netx_pkg::ST_WRITE;
            netx_pkg::ST_WRITE: n_state = netx_pkg::ST_OUT;
            netx_pkg::ST_OUT:   if (i_out_ready) n_state = netx_pkg::ST_IDLE;
            default:            n_state = netx_pkg::ST_IDLE;
        endcase
    end

    always_comb begin
        o_cmd = '0;
        o_in_ready = 1'b0;
        o_out_valid = 1'b0;
        unique case (r_state)
            netx_pkg::ST_IDLE: begin
                o_in_ready = 1'b1;
                o_cmd.load = i_in_valid;
            end
            netx_pkg::ST_SCAN:  o_cmd.scan = 1'b1;
            netx_pkg::ST_READ: begin
                o_cmd.read = 1'b1;
                o_cmd.div_start = i_stat.need_div;
            end
            netx_pkg::ST_DIV:   o_cmd.div_step = 1'b1;
            netx_pkg::ST_WRITE: o_cmd.write = 1'b1;
            netx_pkg::ST_OUT:   o_out_valid = 1'b1;
            default: ;
        endcase
    end

    `ASSERT_IMPL(a_ready_only_idle, i_clk, i_rst_n, o_in_ready, !o_out_valid,
        "input ready while result pending")
    `ASSERT_NEXT(a_accept_scans, i_clk, i_rst_n, o_in_ready && i_in_valid,
        r_state == netx_pkg::ST_SCAN, "accepted item did not start scan")
    `ASSERT_NEXT(a_out_hold, i_clk, i_rst_n, o_out_valid && !i_out_ready,
        o_out_valid, "result dropped while stalled")

endmodule

### rtl/netx_dpath.sv
`include "assert_macros.svh"

module netx_dpath (
    input  logic                     i_clk,
    input  logic                     i_rst_n,
    input  netx_pkg::t_cmd           i_cmd,
    output netx_pkg::t_stat          o_stat,
    input  logic [63:0]              i_dest_addr,
    input  logic                     i_frame_is_ack,
    input  logic                     i_ack_requested,
    input  logic [2:0]               i_acked_on_attempt,
    input  logic [31:0]              i_now_seconds,
    input  logic [2:0]               i_max_tries,
    input  logic [3:0]               i_recalc_count,
    input  logic [15:0]              i_recalc_interval,
    output logic [3:0]               o_entry_index,
    output logic [15:0]              o_link_etx,
    output logic                     o_new_entry,
    output logic                     o_table_full,
    output logic                     o_etx_updated
);

    localparam int N = netx_pkg::TableEntries;
    localparam int IW = netx_pkg::IdxW;
    localparam int CW = netx_pkg::IdxCntW;

    // Table storage: one entry read and one written per cycle.
    logic [63:0] r_addr_mem [N];
    logic [15:0] r_att_mem  [N];
    logic [15:0] r_ack_mem  [N];
    logic [7:0]  r_cd_mem   [N];
    logic [15:0] r_etx_mem  [N];
    logic [31:0] r_nct_mem  [N];
    logic [N-1:0] r_used;

    // Captured item.
    logic [63:0] r_dest;
    logic        r_count_en;
    logic        r_got_ack;
    logic [2:0]  r_n;
    logic [31:0] r_now;

    // Scan state.
    logic [CW-1:0] r_scan_idx;
    logic          r_found, r_free_found;
    logic [IW-1:0] r_match_idx, r_free_idx;
    logic [63:0]   r_rd_addr;

    // Selected entry values.
    logic [IW-1:0] r_sel;
    logic          r_claim, r_full;
    logic [15:0]   r_att, r_ack, r_etx;
    logic [7:0]    r_cd;
    logic          r_upd;

    // Divider.
    logic [15:0] r_quo, r_rem;
    logic [4:0]  r_div_cnt;

    logic [3:0]  r_out_idx;
    logic [15:0] r_out_etx;
    logic        r_out_new, r_out_full, r_out_upd;

    logic [CW-1:0] scan_last;
    logic [IW-1:0] scan_ptr;
    logic          scan_done;
    logic          match_hit;
    logic [16:0]   att_sum;
    logic [15:0]   att_new, ack_new;
    logic [7:0]    cd_new;
    logic [IW-1:0] sel_idx;
    logic          claim;
    logic [16:0]   rem_shift;
    logic [16:0]   rem_sub;
    logic [19:0]   avg_sum;
    logic [15:0]   ratio;

    assign scan_ptr  = r_scan_idx[IW-1:0];
    assign scan_last = CW'(N);
    // The read data register holds the entry just before the one the scan pointer now addresses.
    assign match_hit = (r_scan_idx != '0) && (r_rd_addr == r_dest);
    assign scan_done = r_found || match_hit || (r_scan_idx == scan_last);

    always_ff @(posedge i_clk) begin
        if (i_cmd.scan && !scan_done && r_scan_idx != scan_last) begin
            r_rd_addr <= r_addr_mem[scan_ptr];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_scan_idx <= '0;
            r_found <= 1'b0;
            r_free_found <= 1'b0;
        end else if (i_cmd.load) begin
            r_scan_idx <= '0;
            r_found <= 1'b0;
            r_free_found <= 1'b0;
        end else if (i_cmd.scan && !scan_done) begin
            r_scan_idx <= r_scan_idx + 1'b1;
            if (!r_free_found && !r_used[scan_ptr]) begin
                r_free_found <= 1'b1;
                r_free_idx <= scan_ptr;
            end
        end
        if (i_rst_n && i_cmd.scan && match_hit && !r_found) begin
            r_found <= 1'b1;
            r_match_idx <= IW'(r_scan_idx - 1'b1);
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.load) begin
            r_dest <= i_dest_addr;
            r_now <= i_now_seconds;
            r_count_en <= !i_frame_is_ack && i_ack_requested && (i_max_tries != 3'd0);
            r_got_ack <= (i_acked_on_attempt != 3'd0) && (i_acked_on_attempt <= i_max_tries);
            r_n <= ((i_acked_on_attempt != 3'd0) && (i_acked_on_attempt <= i_max_tries))
                   ? i_acked_on_attempt : i_max_tries;
        end
    end

    // Entry selection after the scan.
    assign claim   = !(r_found || match_hit);
    assign sel_idx = match_hit ? IW'(r_scan_idx - 1'b1) : (r_found ? r_match_idx : r_free_idx);

    always_ff @(posedge i_clk) begin
        if (i_cmd.scan && scan_done) begin
            r_sel <= sel_idx;
            r_claim <= claim && r_free_found;
            r_full <= claim && !r_free_found;
        end
    end

    // Read the entry and apply the attempt and ack counts.
    assign att_sum = {1'b0, (r_claim ? 16'd0 : r_att_mem[r_sel])} + 17'(r_n);
    assign att_new = r_count_en ? (att_sum[16] ? 16'hFFFF : att_sum[15:0])
                                : (r_claim ? 16'd0 : r_att_mem[r_sel]);
    always_comb begin
        logic [15:0] ack_old;
        logic [7:0]  cd_old;
        ack_old = r_claim ? 16'd0 : r_ack_mem[r_sel];
        cd_old  = r_claim ? 8'd1 : r_cd_mem[r_sel];
        ack_new = ack_old;
        cd_new  = cd_old;
        if (r_count_en) begin
            cd_new = (cd_old > 8'(r_n)) ? cd_old - 8'(r_n) : 8'd0;
            if (r_got_ack && ack_old != 16'hFFFF) begin
                ack_new = ack_old + 16'd1;
            end
        end
    end

    logic [15:0] etx_rd;
    logic [31:0] nct_rd;
    logic        need_div;
    assign etx_rd = r_claim ? 16'd0 : r_etx_mem[r_sel];
    assign nct_rd = r_claim ? 32'd0 : r_nct_mem[r_sel];
    assign need_div = r_count_en && r_got_ack && (cd_new == 8'd0)
                      && ((etx_rd == 16'd0) || (r_now >= nct_rd));

    always_ff @(posedge i_clk) begin
        if (i_cmd.read) begin
            r_att <= att_new;
            r_ack <= ack_new;
            r_cd  <= cd_new;
            r_etx <= etx_rd;
            r_upd <= need_div;
        end
    end

    // Restoring division attempts / acks, one quotient bit a cycle.
    assign rem_shift = {r_rem, r_quo[15]};
    assign rem_sub   = rem_shift - {1'b0, r_ack};

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_div_cnt <= '0;
        end else if (i_cmd.div_start) begin
            r_div_cnt <= 5'd16;
            r_quo <= att_new;
            r_rem <= 16'd0;
        end else if (i_cmd.div_step && r_div_cnt != 5'd0) begin
            r_div_cnt <= r_div_cnt - 5'd1;
            if (!rem_sub[16]) begin
                r_rem <= rem_sub[15:0];
                r_quo <= {r_quo[14:0], 1'b1};
            end else begin
                r_rem <= rem_shift[15:0];
                r_quo <= {r_quo[14:0], 1'b0};
            end
        end
    end

    assign ratio   = (r_ack == 16'd0) ? netx_pkg::RatioNoAcks : r_quo;
    assign avg_sum = 20'(ratio) + 20'({r_etx, 3'b000}) - 20'(r_etx);

    // Write back and build the result.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_used <= '0;
        end else if (i_cmd.write && !r_full && r_claim) begin
            r_used[r_sel] <= 1'b1;
        end
    end

    logic [15:0] etx_fin;
    assign etx_fin = r_upd ? ((r_etx == 16'd0) ? ratio : avg_sum[18:3]) : r_etx;

    // Free entries start with address zero and clear counters, so a zero
    // address matches them.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int i = 0; i < N; i++) begin
                r_addr_mem[i] <= '0;
                r_att_mem[i]  <= '0;
                r_ack_mem[i]  <= '0;
                r_cd_mem[i]   <= '0;
                r_etx_mem[i]  <= '0;
                r_nct_mem[i]  <= '0;
            end
        end else if (i_cmd.write && !r_full) begin
            r_addr_mem[r_sel] <= r_dest;
            r_att_mem[r_sel]  <= r_att;
            r_ack_mem[r_sel]  <= r_ack;
            r_cd_mem[r_sel]   <= r_upd ? 8'(i_recalc_count) : r_cd;
            r_etx_mem[r_sel]  <= etx_fin;
            if (r_upd) begin
                r_nct_mem[r_sel] <= r_now + 32'(i_recalc_interval);
            end else if (r_claim) begin
                r_nct_mem[r_sel] <= 32'd0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_idx  <= '0;
            r_out_etx  <= '0;
            r_out_new  <= 1'b0;
            r_out_full <= 1'b0;
            r_out_upd  <= 1'b0;
        end else if (i_cmd.write) begin
            r_out_idx  <= r_full ? 4'd0 : 4'(r_sel);
            r_out_etx  <= r_full ? 16'd0 : etx_fin;
            r_out_new  <= !r_full && r_claim;
            r_out_full <= r_full;
            r_out_upd  <= !r_full && r_upd;
        end
    end

    assign o_stat.scan_done = scan_done;
    assign o_stat.full      = claim && !r_free_found;
    assign o_stat.need_div  = need_div;
    assign o_stat.div_done  = (r_div_cnt == 5'd0);

    assign o_entry_index = r_out_idx;
    assign o_link_etx    = r_out_etx;
    assign o_new_entry   = r_out_new;
    assign o_table_full  = r_out_full;
    assign o_etx_updated = r_out_upd;

    `ASSERT_IMPL(a_full_no_new, i_clk, i_rst_n, r_out_full, !r_out_new && !r_out_upd,
        "full result flags inconsistent")
    `ASSERT_NEXT(a_div_load, i_clk, i_rst_n, i_cmd.div_start, r_div_cnt == 5'd16,
        "divider not loaded")

endmodule

### dv/testbench.sv
`timescale 1ns / 100ps

module testbench;

    localparam int IdleLimit = 5000;
    localparam int PhaseItems = 105;
    localparam int HoldCycles = 300;

    typedef struct {
        logic [63:0] dest;
        logic        is_ack;
        logic        ack_req;
        logic [2:0]  acked_on;
        logic [31:0] now;
    } t_frame;

    typedef struct {
        logic [3:0]  entry_index;
        logic [15:0] link_etx;
        logic        new_entry;
        logic        table_full;
        logic        etx_updated;
    } t_link_result;

    typedef struct {
        t_frame       frame;
        bit           typed;
        t_link_result result;
    } t_dir_row;

    logic         i_clk;
    logic         i_rst_n;
    logic         s_axis_tvalid;
    logic         s_axis_tready;
    logic [103:0] s_axis_tdata;
    logic         m_axis_tvalid;
    logic         m_axis_tready;
    logic [23:0]  m_axis_tdata;
    logic         i_cfg_valid;
    logic         o_cfg_ready;
    logic [1:0]   i_cfg_index;
    logic [15:0]  i_cfg_data;

    // Neighbor table as the testbench sees it.
    bit          nb_used [netx_pkg::TableEntries];
    logic [63:0] nb_addr [netx_pkg::TableEntries];
    logic [15:0] nb_tries [netx_pkg::TableEntries];
    logic [15:0] nb_acks [netx_pkg::TableEntries];
    logic [7:0]  nb_countdown [netx_pkg::TableEntries];
    logic [15:0] nb_etx [netx_pkg::TableEntries];
    logic [31:0] nb_next_time [netx_pkg::TableEntries];
    logic [2:0]  max_tries;
    logic [3:0]  recalc_count;
    logic [15:0] recalc_interval;

    t_link_result pending_results[$];
    bit           offer_typed;
    t_link_result offer_result;
    int           err_count;
    bit           no_idle;
    bit           hold_req;
    int           idle_cycles;

    neighbor_etx_estimator_unit u_dut (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .i_cfg_valid   (i_cfg_valid),
        .o_cfg_ready   (o_cfg_ready),
        .i_cfg_index   (i_cfg_index),
        .i_cfg_data    (i_cfg_data)
    );

    initial begin
        i_clk = 1'b0;
        forever #2 i_clk = ~i_clk;
    end

    // Update the neighbor table for one frame and return the result it yields.
    function automatic t_link_result update_link(t_frame f);
        t_link_result r;
        int hit;
        int free_idx;
        int e;
        bit got_ack;
        int unsigned n;
        int unsigned sum;
        int unsigned ratio;
        int unsigned nv;
        hit = -1;
        free_idx = -1;
        r = '{default: '0};
        for (int i = 0; i < netx_pkg::TableEntries; i++) begin
            if (!nb_used[i] && free_idx < 0) free_idx = i;
            if (nb_addr[i] == f.dest) begin
                hit = i;
                break;
            end
        end
        if (hit < 0) begin
            if (free_idx < 0) begin
                r.table_full = 1'b1;
                return r;
            end
            e = free_idx;
            nb_used[e] = 1'b1;
            nb_addr[e] = f.dest;
            nb_tries[e] = '0;
            nb_acks[e] = '0;
            nb_countdown[e] = 8'd1;
            nb_etx[e] = '0;
            nb_next_time[e] = '0;
            r.new_entry = 1'b1;
        end else begin
            e = hit;
        end
        if (!f.is_ack && f.ack_req && max_tries != 0) begin
            got_ack = f.acked_on >= 1 && f.acked_on <= max_tries;
            n = got_ack ? f.acked_on : max_tries;
            sum = nb_tries[e] + n;
            nb_tries[e] = sum > 16'hFFFF ? 16'hFFFF : sum[15:0];
            nb_countdown[e] = nb_countdown[e] > n ? nb_countdown[e] - n : 8'd0;
            if (got_ack) begin
                if (nb_acks[e] != 16'hFFFF) nb_acks[e]++;
                if (nb_countdown[e] == 0 && (nb_etx[e] == 0 || f.now >= nb_next_time[e])) begin
                    ratio = nb_acks[e] != 0 ? nb_tries[e] / nb_acks[e] : 511;
                    nv = nb_etx[e] == 0 ? ratio : (ratio + 7 * nb_etx[e]) / 8;
                    nb_etx[e] = nv > 16'hFFFF ? 16'hFFFF : nv[15:0];
                    nb_countdown[e] = {4'd0, recalc_count};
                    nb_next_time[e] = f.now + {16'd0, recalc_interval};
                    r.etx_updated = 1'b1;
                end
            end
        end
        r.entry_index = e[3:0];
        r.link_etx = nb_etx[e];
        return r;
    endfunction

    task automatic report_mismatch(string field, int unsigned got, int unsigned exp_val);
        $display("mismatch on %s at %0t: got %0d, expected %0d", field, $realtime, got, exp_val);
        err_count++;
    endtask

    // Track config writes, predict on each input transfer, check each result transfer.
    always @(posedge i_clk) begin
        t_link_result want;
        t_frame f;
        if (i_rst_n) begin
            if (i_cfg_valid && o_cfg_ready) begin
                case (i_cfg_index)
                    netx_pkg::CfgMaxTries:       max_tries = i_cfg_data[2:0];
                    netx_pkg::CfgRecalcCount:    recalc_count = i_cfg_data[3:0];
                    netx_pkg::CfgRecalcInterval: recalc_interval = i_cfg_data;
                    default: ;
                endcase
            end
            if (s_axis_tvalid && s_axis_tready) begin
                f.dest = s_axis_tdata[63:0];
                f.is_ack = s_axis_tdata[64];
                f.ack_req = s_axis_tdata[65];
                f.acked_on = s_axis_tdata[68:66];
                f.now = s_axis_tdata[100:69];
                want = update_link(f);
                // typed rows override the prediction, state still advances
                pending_results.push_back(offer_typed ? offer_result : want);
            end
            if (m_axis_tvalid && m_axis_tready) begin
                if (pending_results.size() == 0) begin
                    report_mismatch("unexpected result transfer", 1, 0);
                end else begin
                    want = pending_results.pop_front();
                    if (m_axis_tdata[3:0] != want.entry_index)
                        report_mismatch("entry_index", m_axis_tdata[3:0], want.entry_index);
                    if (m_axis_tdata[19:4] != want.link_etx)
                        report_mismatch("link_etx", m_axis_tdata[19:4], want.link_etx);
                    if (m_axis_tdata[20] != want.new_entry)
                        report_mismatch("new_entry", m_axis_tdata[20], want.new_entry);
                    if (m_axis_tdata[21] != want.table_full)
                        report_mismatch("table_full", m_axis_tdata[21], want.table_full);
                    if (m_axis_tdata[22] != want.etx_updated)
                        report_mismatch("etx_updated", m_axis_tdata[22], want.etx_updated);
                end
            end
        end
    end

    // Watchdog: end the run if nothing moves for too long.
    always @(posedge i_clk) begin
        if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready)
                || (i_cfg_valid && o_cfg_ready) || !i_rst_n) begin
            idle_cycles = 0;
        end else begin
            idle_cycles++;
            if (idle_cycles >= IdleLimit) begin
                $display("RESULT: ERROR");
                $finish;
            end
        end
    end

    function automatic int pick_gap();
        int r;
        r = $urandom_range(0, 99);
        if (no_idle || r < 55) return 0;
        if (r < 92) return $urandom_range(1, 3);
        return $urandom_range(10, 40);
    endfunction

    // Result side: random back-pressure, plus one long hold-off on request.
    initial begin
        m_axis_tready = 1'b0;
        forever begin
            @(negedge i_clk);
            if (hold_req) begin
                hold_req = 1'b0;
                m_axis_tready <= 1'b0;
                repeat (HoldCycles) @(negedge i_clk);
            end else if (!no_idle && $urandom_range(0, 39) == 0) begin
                m_axis_tready <= 1'b0;
                repeat ($urandom_range(10, 40)) @(negedge i_clk);
            end else begin
                m_axis_tready <= no_idle || $urandom_range(0, 3) != 0;
            end
        end
    end

    // Offer one frame at a falling edge; return at a falling edge after the transfer.
    task automatic send_frame(t_frame f, bit typed, t_link_result typed_result);
        int gap;
        offer_typed = typed;
        offer_result = typed_result;
        s_axis_tdata <= {3'b000, f.now, f.acked_on, f.ack_req, f.is_ack, f.dest};
        s_axis_tvalid <= 1'b1;
        do @(posedge i_clk); while (!(s_axis_tvalid && s_axis_tready));
        @(negedge i_clk);
        gap = pick_gap();
        if (gap > 0) begin
            s_axis_tvalid <= 1'b0;
            repeat (gap) @(negedge i_clk);
        end
    endtask

    task automatic write_reg(logic [1:0] idx, logic [15:0] value);
        i_cfg_index <= idx;
        i_cfg_data <= value;
        i_cfg_valid <= 1'b1;
        do @(posedge i_clk); while (!(i_cfg_valid && o_cfg_ready));
        @(negedge i_clk);
        i_cfg_valid <= 1'b0;
    endtask

    // Drain the block, then let it settle before touching registers.
    task automatic drain();
        s_axis_tvalid <= 1'b0;
        while (pending_results.size() != 0) @(negedge i_clk);
        repeat (60) @(negedge i_clk);
    endtask

    initial begin
        t_dir_row     rows[$];
        t_dir_row     row;
        t_frame       f;
        t_link_result none;
        logic [31:0]  clock_s;
        int unsigned  phase_cfg[6][3];

        phase_cfg = '{'{1, 1, 0}, '{7, 15, 65535}, '{0, 4, 60},
                      '{2, 1, 5}, '{5, 2, 30}, '{7, 1, 0}};
        i_rst_n = 1'b0;
        s_axis_tvalid = 1'b0;
        s_axis_tdata = '0;
        m_axis_tready = 1'b0;
        i_cfg_valid = 1'b0;
        i_cfg_index = netx_pkg::CfgMaxTries;
        i_cfg_data = '0;
        err_count = 0;
        no_idle = 1'b0;
        hold_req = 1'b0;
        idle_cycles = 0;
        offer_typed = 1'b0;
        none = '{default: '0};
        offer_result = none;
        for (int i = 0; i < netx_pkg::TableEntries; i++) begin
            nb_used[i] = 0; nb_addr[i] = '0; nb_tries[i] = '0; nb_acks[i] = '0;
            nb_countdown[i] = '0; nb_etx[i] = '0; nb_next_time[i] = '0;
        end
        max_tries = netx_pkg::MaxTriesRst;
        recalc_count = netx_pkg::RecalcCountRst;
        recalc_interval = netx_pkg::RecalcIntervalRst;

        // Directed table. Address zero first hits a free, never-written entry.
        row.frame = '{64'd0, 1'b0, 1'b1, 3'd1, 32'd0};
        row.typed = 1'b1;
        row.result = '{4'd0, 16'd1, 1'b0, 1'b0, 1'b1};
        rows.push_back(row);
        // Fill the table with varied flags: no ack, ack frame, no ack request,
        // ack beyond max_tries, last attempt.
        for (int k = 1; k <= netx_pkg::TableEntries; k++) begin
            row.typed = 1'b0;
            row.result = none;
            row.frame.dest = k == netx_pkg::TableEntries ? 64'hFFFF_FFFF_FFFF_FFFF
                                                          : 64'h0123_4567_89AB_CDEF * k;
            row.frame.is_ack = k % 5 == 2;
            row.frame.ack_req = k % 4 != 3;
            row.frame.acked_on = 3'(k % 8);
            row.frame.now = k == 8 ? 32'hFFFF_FFFF : 32'(k);
            rows.push_back(row);
        end
        // Table full: unknown address, then address zero, which no entry holds now.
        row.typed = 1'b1;
        row.result = '{4'd0, 16'd0, 1'b0, 1'b1, 1'b0};
        row.frame = '{64'h8000_0000_0000_0000, 1'b0, 1'b1, 3'd1, 32'd20};
        rows.push_back(row);
        row.frame = '{64'd0, 1'b0, 1'b1, 3'd2, 32'd21};
        rows.push_back(row);
        // Hits on a claimed entry to walk the countdown and moving average.
        row.typed = 1'b0;
        row.result = none;
        row.frame = '{64'h0123_4567_89AB_CDEF, 1'b0, 1'b1, 3'd3, 32'd30};
        rows.push_back(row);
        row.frame.acked_on = 3'd7;
        rows.push_back(row);
        row.frame.acked_on = 3'd1;
        row.frame.now = 32'd100;
        rows.push_back(row);
        row.frame.acked_on = 3'd2;
        row.frame.now = 32'd200;
        rows.push_back(row);

        repeat (9) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n = 1'b1;

        foreach (rows[i]) send_frame(rows[i].frame, rows[i].typed, rows[i].result);
        offer_typed = 1'b0;

        clock_s = 32'd1000;
        for (int p = 0; p < 6; p++) begin
            drain();
            write_reg(netx_pkg::CfgMaxTries, 16'(phase_cfg[p][0]));
            write_reg(netx_pkg::CfgRecalcCount, 16'(phase_cfg[p][1]));
            write_reg(netx_pkg::CfgRecalcInterval, 16'(phase_cfg[p][2]));
            no_idle = p == 3;
            // Long result-side stall while frames keep coming.
            if (p == 1) hold_req = 1'b1;
            for (int n = 0; n < PhaseItems; n++) begin
                if ($urandom_range(0, 99) < 85)
                    f.dest = nb_addr[$urandom_range(0, netx_pkg::TableEntries - 1)];
                else
                    f.dest = {$urandom, $urandom};
                f.is_ack = $urandom_range(0, 9) == 0;
                f.ack_req = $urandom_range(0, 9) != 0;
                f.acked_on = $urandom_range(0, 7);
                // Mostly a slowly advancing clock, sometimes a jump anywhere.
                if ($urandom_range(0, 19) == 0) clock_s = $urandom;
                else clock_s = clock_s + $urandom_range(0, 25);
                f.now = clock_s;
                send_frame(f, 1'b0, none);
            end
        end

        drain();
        if (err_count == 0)
            $display("RESULT: OK");
        else
            $display("RESULT: ERROR");
        $finish;
    end

endmodule

### neighbor_etx_estimator_unit.f
+incdir+rtl
rtl/netx_pkg.sv
rtl/netx_ctrl.sv
rtl/netx_dpath.sv
rtl/neighbor_etx_estimator_unit.sv
dv/testbench.sv
